// File: rtl/core/plps_pkg.sv
package plps_pkg;

   localparam int VEC_W  = 35;
   localparam int UNIT_W = 16;
   localparam int Q28_W  = 29;
   localparam int FRAC   = 28;

   localparam logic [Q28_W-1:0] ONE_Q28  = Q28_W'(1) << FRAC;
   localparam logic [2*Q28_W-1:0] HALF_Q28 = (2*Q28_W)'(1) << (FRAC - 1);

   typedef logic signed [VEC_W-1:0]  vec_type;
   typedef vec_type [2:0]            vec3_type;
   typedef logic signed [UNIT_W-1:0] unit_type;
   typedef unit_type [2:0]           unit3_type;

   typedef struct packed {
      logic signed [31:0] hit_x;
      logic signed [31:0] hit_y;
      logic signed [31:0] hit_z;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
      logic [7:0]         shine_exp;
      logic [31:0]        intensity_in;
   } req_type;

   typedef struct packed {
      logic        lit;
      logic [31:0] intensity_out;
      logic [31:0] color_out;
   } rsp_type;

   typedef enum logic [2:0] {
      REG_LIGHT_X        = 3'd0,
      REG_LIGHT_Y        = 3'd1,
      REG_LIGHT_Z        = 3'd2,
      REG_LIGHT_STRENGTH = 3'd3,
      REG_LIGHT_RGBA     = 3'd4,
      REG_EYE_X          = 3'd5,
      REG_EYE_Y          = 3'd6,
      REG_EYE_Z          = 3'd7
   } reg_idx_type;

endpackage

// File: rtl/core/plps_norm.sv
module plps_norm
   import plps_pkg::*;
#(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  vec3_type          in_vec,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output unit3_type         out_unit,
   output logic [SIDE_W-1:0] out_side
);

   localparam int MW        = 34;
   localparam int SW        = 30;
   localparam int BLW       = 6;
   localparam int ISQ_STEPS = 32;
   localparam int QW        = 15;
   localparam int RW        = 45;
   localparam int LW        = 31;
   localparam int LAT       = 54;

   typedef struct packed {
      logic [2:0][SW-1:0] m;
      logic [2:0]         neg;
      logic               zero;
   } ncarry_type;

   logic [LAT-1:0]    vld_ff;
   logic [SIDE_W-1:0] side_ff [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int k = 1; k < LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[LAT-1];
   assign out_side  = side_ff[LAT-1];

   logic [2:0][MW-1:0] mag0_ff;
   logic [2:0]         neg0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            neg0_ff[i] <= in_vec[i][VEC_W-1];
            mag0_ff[i] <= in_vec[i][VEC_W-1] ? MW'(-in_vec[i]) : MW'(in_vec[i]);
         end
      end
   end

   logic [MW-1:0]  mx;
   logic [BLW-1:0] bl;

   always_comb begin
      mx = mag0_ff[0];
      if (mag0_ff[1] > mx) mx = mag0_ff[1];
      if (mag0_ff[2] > mx) mx = mag0_ff[2];
      bl = '0;
      for (int j = 0; j < MW; j++) begin
         if (mx[j]) bl = BLW'(j + 1);
      end
   end

   logic [2:0][MW-1:0] mag1_ff;
   logic [2:0]         neg1_ff;
   logic [BLW-1:0]     bl1_ff;
   logic               zero1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         mag1_ff  <= mag0_ff;
         neg1_ff  <= neg0_ff;
         bl1_ff   <= bl;
         zero1_ff <= (mx == '0);
      end
   end

   logic [2:0][SW-1:0] m2_ff;
   logic [2:0]         neg2_ff;
   logic               zero2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            if (bl1_ff > BLW'(SW)) begin
               m2_ff[i] <= SW'(mag1_ff[i] >> (bl1_ff - BLW'(SW)));
            end else begin
               m2_ff[i] <= SW'(mag1_ff[i] << (BLW'(SW) - bl1_ff));
            end
         end
         neg2_ff  <= neg1_ff;
         zero2_ff <= zero1_ff;
      end
   end

   logic [2:0][2*SW-1:0] sq3_ff;
   ncarry_type           nc3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq3_ff[i] <= (2*SW)'(m2_ff[i]) * (2*SW)'(m2_ff[i]);
         end
         nc3_ff.m    <= m2_ff;
         nc3_ff.neg  <= neg2_ff;
         nc3_ff.zero <= zero2_ff;
      end
   end

   logic [63:0] isq_x_ff  [ISQ_STEPS];
   logic [63:0] isq_r_ff  [ISQ_STEPS+1];
   ncarry_type  isq_nc_ff [ISQ_STEPS+1];

   always_ff @(posedge clock) begin
      if (en) begin
         isq_x_ff[0]  <= 64'(sq3_ff[0]) + 64'(sq3_ff[1]) + 64'(sq3_ff[2]);
         isq_r_ff[0]  <= '0;
         isq_nc_ff[0] <= nc3_ff;
      end
   end

   for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_isq
      localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
      logic [63:0] trial;
      logic        ge;
      assign trial = isq_r_ff[k] + BIT;
      assign ge    = (isq_x_ff[k] >= trial);
      always_ff @(posedge clock) begin
         if (en) begin
            isq_r_ff[k+1]  <= ge ? (isq_r_ff[k] >> 1) + BIT : isq_r_ff[k] >> 1;
            isq_nc_ff[k+1] <= isq_nc_ff[k];
         end
      end
      if (k < ISQ_STEPS - 1) begin : g_x
         always_ff @(posedge clock) begin
            if (en) begin
               isq_x_ff[k+1] <= ge ? isq_x_ff[k] - trial : isq_x_ff[k];
            end
         end
      end
   end

   logic [LW-1:0]      len;
   ncarry_type         nc_last;
   logic [2:0][RW-1:0] rem_ff  [QW];
   logic [LW-1:0]      len_ff  [QW];
   logic [2:0][QW-1:0] q_ff    [QW+1];
   logic [2:0]         dneg_ff [QW+1];
   logic               dzero_ff[QW+1];

   assign len     = isq_r_ff[ISQ_STEPS][LW-1:0];
   assign nc_last = isq_nc_ff[ISQ_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            rem_ff[0][i] <= RW'({nc_last.m[i], 14'b0}) + RW'(len >> 1);
         end
         len_ff[0]   <= len;
         q_ff[0]     <= '0;
         dneg_ff[0]  <= nc_last.neg;
         dzero_ff[0] <= nc_last.zero;
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_div
      localparam int SH = QW - 1 - j;
      logic [RW-1:0] dvs;
      logic [2:0]    ge;
      assign dvs = RW'(len_ff[j]) << SH;
      always_comb begin
         for (int i = 0; i < 3; i++) begin
            ge[i] = (rem_ff[j][i] >= dvs);
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               q_ff[j+1][i] <= {q_ff[j][i][QW-2:0], ge[i]};
            end
            dneg_ff[j+1]  <= dneg_ff[j];
            dzero_ff[j+1] <= dzero_ff[j];
         end
      end
      if (j < QW - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               for (int i = 0; i < 3; i++) begin
                  rem_ff[j+1][i] <= ge[i] ? rem_ff[j][i] - dvs : rem_ff[j][i];
               end
               len_ff[j+1] <= len_ff[j];
            end
         end
      end
   end

   unit3_type unit_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            if (dzero_ff[QW]) begin
               unit_ff[i] <= '0;
            end else if (dneg_ff[QW][i]) begin
               unit_ff[i] <= -UNIT_W'(q_ff[QW][i]);
            end else begin
               unit_ff[i] <= UNIT_W'(q_ff[QW][i]);
            end
         end
      end
   end

   assign out_unit = unit_ff;

endmodule

// File: rtl/core/plps_pow.sv
module plps_pow
   import plps_pkg::*;
#(
   parameter int EXP_BITS = 8,
   parameter int SIDE_W   = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [Q28_W-1:0]    in_base,
   input  logic [EXP_BITS-1:0] in_exp,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [Q28_W-1:0]    out_pow,
   output logic [SIDE_W-1:0]   out_side
);

   localparam int PW = 2 * Q28_W;

   logic                vld_s  [EXP_BITS+1];
   logic [Q28_W-1:0]    base_s [EXP_BITS];
   logic [Q28_W-1:0]    pow_s  [EXP_BITS+1];
   logic [EXP_BITS-1:0] exp_s  [EXP_BITS];
   logic [SIDE_W-1:0]   side_s [EXP_BITS+1];

   assign vld_s[0]  = in_valid;
   assign base_s[0] = in_base;
   assign pow_s[0]  = ONE_Q28;
   assign exp_s[0]  = in_exp;
   assign side_s[0] = in_side;

   for (genvar k = 0; k < EXP_BITS; k++) begin : g_step
      logic                vld_ff;
      logic [Q28_W-1:0]    pow_ff;
      logic [SIDE_W-1:0]   side_ff;
      logic [PW-1:0]       pb_prod;

      assign pb_prod = PW'(pow_s[k]) * PW'(base_s[k]) + HALF_Q28;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= vld_s[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            pow_ff  <= exp_s[k][k] ? pb_prod[FRAC+Q28_W-1:FRAC] : pow_s[k];
            side_ff <= side_s[k];
         end
      end

      assign vld_s[k+1]  = vld_ff;
      assign pow_s[k+1]  = pow_ff;
      assign side_s[k+1] = side_ff;

      if (k < EXP_BITS - 1) begin : g_sq
         logic [Q28_W-1:0]    base_ff;
         logic [EXP_BITS-1:0] exp_ff;
         logic [PW-1:0]       bb_prod;

         assign bb_prod = PW'(base_s[k]) * PW'(base_s[k]) + HALF_Q28;

         always_ff @(posedge clock) begin
            if (en) begin
               base_ff <= bb_prod[FRAC+Q28_W-1:FRAC];
               exp_ff  <= exp_s[k];
            end
         end

         assign base_s[k+1] = base_ff;
         assign exp_s[k+1]  = exp_ff;
      end
   end

   assign out_valid = vld_s[EXP_BITS];
   assign out_pow   = pow_s[EXP_BITS];
   assign out_side  = side_s[EXP_BITS];

endmodule

// File: rtl/core/point_light_phong_shade.sv
// Point-light Phong shader: one surface hit in, one shaded result out, one hit per clock
// while the rsp channel is not stalled. The direction to the light, the reflected light
// direction and the direction to the eye are each normalized by a 54-stage unit (bit-serial
// square root, then a 15-step divider); the specular power runs one square-and-multiply
// stage per exponent bit. A stalled rsp channel holds the whole pipeline, so req_ready
// follows rsp_ready whenever a result is waiting. Light and eye registers may only be
// rewritten while no hit is in flight.
module point_light_phong_shade
   import plps_pkg::*;
#(
   parameter int EXP_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = 37;

   logic [31:0] light_x_ff, light_y_ff, light_z_ff, light_strength_ff, light_rgba_ff;
   logic [31:0] eye_x_ff, eye_y_ff, eye_z_ff;
   reg_idx_type csr_idx;

   assign csr_idx    = reg_idx_type'(csr_paddr[4:2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_x_ff        <= '0;
         light_y_ff        <= '0;
         light_z_ff        <= '0;
         light_strength_ff <= 32'h0001_0000;
         light_rgba_ff     <= 32'hFFFF_FFFF;
         eye_x_ff          <= '0;
         eye_y_ff          <= '0;
         eye_z_ff          <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_idx)
            REG_LIGHT_X:        light_x_ff        <= csr_pwdata;
            REG_LIGHT_Y:        light_y_ff        <= csr_pwdata;
            REG_LIGHT_Z:        light_z_ff        <= csr_pwdata;
            REG_LIGHT_STRENGTH: light_strength_ff <= csr_pwdata;
            REG_LIGHT_RGBA:     light_rgba_ff     <= csr_pwdata;
            REG_EYE_X:          eye_x_ff          <= csr_pwdata;
            REG_EYE_Y:          eye_y_ff          <= csr_pwdata;
            REG_EYE_Z:          eye_z_ff          <= csr_pwdata;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_LIGHT_X:        csr_prdata = light_x_ff;
         REG_LIGHT_Y:        csr_prdata = light_y_ff;
         REG_LIGHT_Z:        csr_prdata = light_z_ff;
         REG_LIGHT_STRENGTH: csr_prdata = light_strength_ff;
         REG_LIGHT_RGBA:     csr_prdata = light_rgba_ff;
         REG_EYE_X:          csr_prdata = eye_x_ff;
         REG_EYE_Y:          csr_prdata = eye_y_ff;
         REG_EYE_Z:          csr_prdata = eye_z_ff;
      endcase
   end

   logic    en;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // input stage
   logic    in_vld_ff;
   req_type in_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (en) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_ff <= req_data;
      end
   end

   vec3_type dl, dv;

   assign dl[0] = VEC_W'($signed(light_x_ff)) - VEC_W'(in_ff.hit_x);
   assign dl[1] = VEC_W'($signed(light_y_ff)) - VEC_W'(in_ff.hit_y);
   assign dl[2] = VEC_W'($signed(light_z_ff)) - VEC_W'(in_ff.hit_z);
   assign dv[0] = VEC_W'($signed(eye_x_ff)) - VEC_W'(in_ff.hit_x);
   assign dv[1] = VEC_W'($signed(eye_y_ff)) - VEC_W'(in_ff.hit_y);
   assign dv[2] = VEC_W'($signed(eye_z_ff)) - VEC_W'(in_ff.hit_z);

   typedef struct packed {
      unit3_type           nrm;
      logic [EXP_BITS-1:0] e;
   } lside_type;

   lside_type   l_side_in, l_side_out;
   logic [31:0] v_side_out;
   logic        l_vld, v_vld;
   unit3_type   ldir, vdir;

   assign l_side_in.nrm[0] = in_ff.norm_x;
   assign l_side_in.nrm[1] = in_ff.norm_y;
   assign l_side_in.nrm[2] = in_ff.norm_z;
   assign l_side_in.e      = EXP_BITS'(in_ff.shine_exp);

   plps_norm #(.SIDE_W($bits(lside_type))) u_norm_l (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (in_vld_ff),
      .in_vec   (dl),
      .in_side  (l_side_in),
      .out_valid(l_vld),
      .out_unit (ldir),
      .out_side (l_side_out)
   );

   plps_norm #(.SIDE_W(32)) u_norm_v (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (in_vld_ff),
      .in_vec   (dv),
      .in_side  (in_ff.intensity_in),
      .out_valid(v_vld),
      .out_unit (vdir),
      .out_side (v_side_out)
   );

   // cosine stage
   logic signed [33:0] c_sum;

   assign c_sum = 34'(l_side_out.nrm[0] * ldir[0])
                + 34'(l_side_out.nrm[1] * ldir[1])
                + 34'(l_side_out.nrm[2] * ldir[2]);

   logic                c_vld_ff;
   logic signed [31:0]  c_ff;
   unit3_type           c_ldir_ff, c_vdir_ff, c_nrm_ff;
   logic [EXP_BITS-1:0] c_e_ff;
   logic [31:0]         c_acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (en) begin
         c_vld_ff <= l_vld & v_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff      <= 32'(c_sum);
         c_ldir_ff <= ldir;
         c_vdir_ff <= vdir;
         c_nrm_ff  <= l_side_out.nrm;
         c_e_ff    <= l_side_out.e;
         c_acc_ff  <= v_side_out;
      end
   end

   // diffuse and reflection products
   logic                   d_vld_ff;
   logic signed [2:0][47:0] d_prod_ff;
   logic [34:0]            d_diff_ff;
   logic                   d_lit_ff;
   unit3_type              d_ldir_ff, d_vdir_ff;
   logic [EXP_BITS-1:0]    d_e_ff;
   logic [31:0]            d_acc_ff;
   logic [62:0]            diff_prod;

   assign diff_prod = 63'(light_strength_ff) * 63'(c_ff[30:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (en) begin
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            d_prod_ff[i] <= (48'(c_ff) * 48'(c_nrm_ff[i])) <<< 1;
         end
         d_diff_ff <= diff_prod[62:28];
         d_lit_ff  <= !c_ff[31];
         d_ldir_ff <= c_ldir_ff;
         d_vdir_ff <= c_vdir_ff;
         d_e_ff    <= c_e_ff;
         d_acc_ff  <= c_acc_ff;
      end
   end

   // reflected vector and diffuse sum
   vec3_type r_vec;

   always_comb begin
      logic [47:0] pm;
      logic [47:0] rs;
      for (int i = 0; i < 3; i++) begin
         pm = d_prod_ff[i][47] ? 48'(-d_prod_ff[i]) : 48'(d_prod_ff[i]);
         rs = (pm + (48'd1 << 27)) >> 28;
         r_vec[i] = (d_prod_ff[i][47] ? -VEC_W'(rs[19:0]) : VEC_W'(rs[19:0]))
                  - VEC_W'(d_ldir_ff[i]);
      end
   end

   logic                e_vld_ff;
   vec3_type            e_r_ff;
   unit3_type           e_vdir_ff;
   logic [EXP_BITS-1:0] e_e_ff;
   logic [AW-1:0]       e_acc_ff;
   logic                e_lit_ff;
   logic                e_spec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (en) begin
         e_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_r_ff    <= r_vec;
         e_vdir_ff <= d_vdir_ff;
         e_e_ff    <= d_e_ff;
         e_acc_ff  <= d_lit_ff ? AW'(d_acc_ff) + AW'(d_diff_ff) : AW'(d_acc_ff);
         e_lit_ff  <= d_lit_ff;
         e_spec_ff <= d_lit_ff && (d_e_ff != '0);
      end
   end

   typedef struct packed {
      unit3_type           vdir;
      logic [EXP_BITS-1:0] e;
      logic [AW-1:0]       acc;
      logic                lit;
      logic                spec;
   } rside_type;

   rside_type r_side_in, r_side_out;
   logic      r_vld;
   unit3_type rdir;

   assign r_side_in.vdir = e_vdir_ff;
   assign r_side_in.e    = e_e_ff;
   assign r_side_in.acc  = e_acc_ff;
   assign r_side_in.lit  = e_lit_ff;
   assign r_side_in.spec = e_spec_ff;

   plps_norm #(.SIDE_W($bits(rside_type))) u_norm_r (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (e_vld_ff),
      .in_vec   (e_r_ff),
      .in_side  (r_side_in),
      .out_valid(r_vld),
      .out_unit (rdir),
      .out_side (r_side_out)
   );

   // R.V and clamp
   logic signed [33:0] rv;

   assign rv = 34'(rdir[0] * r_side_out.vdir[0])
             + 34'(rdir[1] * r_side_out.vdir[1])
             + 34'(rdir[2] * r_side_out.vdir[2]);

   typedef struct packed {
      logic [AW-1:0] acc;
      logic          lit;
      logic          spec;
   } pside_type;

   logic                f_vld_ff;
   logic [Q28_W-1:0]    f_base_ff;
   logic [EXP_BITS-1:0] f_e_ff;
   pside_type           f_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (en) begin
         f_vld_ff <= r_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_base_ff      <= (rv > 34'(ONE_Q28)) ? ONE_Q28 : rv[Q28_W-1:0];
         f_e_ff         <= r_side_out.e;
         f_side_ff.acc  <= r_side_out.acc;
         f_side_ff.lit  <= r_side_out.lit;
         f_side_ff.spec <= r_side_out.spec && (rv > 34'sd0);
      end
   end

   logic             p_vld;
   logic [Q28_W-1:0] p_pow;
   pside_type        p_side;

   plps_pow #(.EXP_BITS(EXP_BITS), .SIDE_W($bits(pside_type))) u_pow (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (f_vld_ff),
      .in_base  (f_base_ff),
      .in_exp   (f_e_ff),
      .in_side  (f_side_ff),
      .out_valid(p_vld),
      .out_pow  (p_pow),
      .out_side (p_side)
   );

   // specular term
   logic [60:0]   spec_prod;
   logic          g_vld_ff;
   logic [32:0]   g_spec_ff;
   logic [AW-1:0] g_acc_ff;
   logic          g_lit_ff;

   assign spec_prod = 61'(light_strength_ff) * 61'(p_pow);

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else if (en) begin
         g_vld_ff <= p_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g_spec_ff <= p_side.spec ? spec_prod[60:28] : '0;
         g_acc_ff  <= p_side.acc;
         g_lit_ff  <= p_side.lit;
      end
   end

   // saturate and hold for transfer
   logic [AW:0] total;

   assign total = (AW+1)'(g_acc_ff) + (AW+1)'(g_spec_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= g_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff.lit           <= g_lit_ff;
         rsp_data_ff.intensity_out <= (total > (AW+1)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                       : total[31:0];
         rsp_data_ff.color_out     <= g_lit_ff ? light_rgba_ff : '0;
      end
   end

endmodule
